FILE: src/touch_stroke_interpolator_top_defines.svh
// ----------------------------------------------------------------------------
// touch stroke interpolator assertion macros
// shared concurrent assertion forms, clocked on clk, quiet while arst_n is low
// ----------------------------------------------------------------------------
`ifndef TOUCH_STROKE_INTERPOLATOR_TOP_DEFINES_SVH
`define TOUCH_STROKE_INTERPOLATOR_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TSI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("touch stroke interpolator: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define TSI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("touch stroke interpolator: next-cycle check failed");

`endif

FILE: src/tsi_pkg.sv
// ----------------------------------------------------------------------------
// tsi_pkg
// types and constants shared by the touch stroke interpolator modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsi_pkg;

	localparam int COORD_W  = 10;
	localparam int TIME_W   = 32;
	localparam int GAP_W    = 16;
	localparam int STEP_W   = 8;
	localparam int CAP_W    = 7;
	localparam int SLOT_W   = 9;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	// divider: quotient always fits the coordinate width
	localparam int NUM_W    = 16;
	localparam int DEN_W    = 8;
	localparam int QUO_W    = COORD_W;
	localparam int BITS_PER_CYC = 2;
	localparam int DIV_CYCLES = QUO_W / BITS_PER_CYC;
	localparam int DIV_CNT_W = $clog2(DIV_CYCLES);

	localparam logic [CAP_W-1:0] RESULT_CAP = 7'd64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAP  = 2'd2;

	localparam logic [GAP_W-1:0]  GAP_RESET  = 16'd250;
	localparam logic [STEP_W-1:0] STEP_RESET = 8'd8;
	localparam logic [CAP_W-1:0]  CAP_RESET  = 7'd40;

	typedef struct packed {
		logic             go;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

endpackage

FILE: src/tsi_div.sv
// ----------------------------------------------------------------------------
// tsi_div
// shared restoring divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsi_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tsi_pkg::div_req_t  req,
	output tsi_pkg::div_rsp_t  rsp
);
	import tsi_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [QUO_W-1:0]     sh_q;
	logic [DEN_W-1:0]     rem_n;
	logic [QUO_W-1:0]     sh_n;

	// caller guarantees num / den < 2**QUO_W, so the upper bits start as remainder
	always_comb begin
		logic [DEN_W:0] t;
		rem_n = rem_q;
		sh_n  = sh_q;
		t     = '0;
		for (int k = 0; k < BITS_PER_CYC; k++) begin
			t    = {rem_n, sh_n[QUO_W-1]};
			sh_n = {sh_n[QUO_W-2:0], 1'b0};
			if (t >= {1'b0, den_q}) begin
				t       = t - {1'b0, den_q};
				sh_n[0] = 1'b1;
			end
			rem_n = t[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= DEN_W'(req.num[NUM_W-1:QUO_W]);
			sh_q  <= req.num[QUO_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= rem_n;
			sh_q  <= sh_n;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = sh_q;

endmodule

FILE: src/touch_stroke_interpolator_top.sv
// ----------------------------------------------------------------------------
// touch_stroke_interpolator_top
// turns touch samples into evenly spaced trail points with ring slots
// ----------------------------------------------------------------------------
// A touch sample (kind 0) that arrives less than the gap register after the last
// point of a live stroke is joined to that point by max(|dx|,|dy|)/step_pixels
// points, clamped to 1..max_steps (a cap of 0 counts as 1, above 64 as 64);
// any other sample gives the new point alone, and a finger lift (kind 1) ends
// the stroke and gives nothing. All division runs through one shared radix-4
// divider, which is loaded and then iterates: one division sizes the stroke
// segment, then each point takes one division for x and one for y. A sample
// is held while the output side holds ready low. in_ready is low while a
// sample is being worked on; the output register lets the next transaction be
// taken while the final point still waits. Configuration may be written any
// time the block is idle; an unknown register index is ignored.
`timescale 1ns / 1ps

module touch_stroke_interpolator_top #(
	parameter int RING_DEPTH = 512
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// sample channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic [tsi_pkg::COORD_W-1:0]       touch_x,
	input  logic [tsi_pkg::COORD_W-1:0]       touch_y,
	input  logic [tsi_pkg::TIME_W-1:0]        now_ms,
	// point channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tsi_pkg::COORD_W-1:0]       point_x,
	output logic [tsi_pkg::COORD_W-1:0]       point_y,
	output logic [tsi_pkg::TIME_W-1:0]        stamp,
	output logic [tsi_pkg::SLOT_W-1:0]        slot,
	output logic                              last_point,
	// configuration channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tsi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tsi_pkg::CFG_W-1:0]         cfg_data
);
	import tsi_pkg::*;

	localparam int HW = $clog2(RING_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPAN,
		ST_XDIV,
		ST_YDIV,
		ST_EMIT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [GAP_W-1:0]  gap_q;
	logic [STEP_W-1:0] step_q;
	logic [CAP_W-1:0]  cap_q;

	// stroke state
	logic [COORD_W-1:0] prev_x_q, prev_y_q;
	logic [TIME_W-1:0]  prev_time_q;
	logic               have_prev_q;
	logic [HW-1:0]      head_q;

	// per-sample working registers
	logic [COORD_W-1:0] base_x_q, base_y_q;
	logic               neg_x_q, neg_y_q;
	logic [COORD_W-1:0] adx_q, ady_q;
	logic [NUM_W-1:0]   acc_x_q, acc_y_q;
	logic [CAP_W-1:0]   steps_q, idx_q;
	logic [COORD_W-1:0] qx_q;
	logic [TIME_W-1:0]  stamp_q;
	logic [COORD_W-1:0] pend_x_q, pend_y_q;
	logic               pend_last_q;

	// output register
	logic               out_valid_q;
	logic [COORD_W-1:0] px_q, py_q;
	logic [TIME_W-1:0]  stamp_out_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               last_q;

	div_req_t req_q;
	div_rsp_t rsp;

	// input-side arithmetic, used on the accepting edge
	logic               in_take;
	logic               in_neg_x, in_neg_y;
	logic [COORD_W-1:0] in_adx, in_ady, in_span;
	logic [TIME_W-1:0]  elapsed;
	logic               joins;
	logic [STEP_W-1:0]  step_eff;
	logic [CAP_W-1:0]   cap_eff;
	logic [CAP_W-1:0]   steps_n;
	logic [COORD_W-1:0] nx, ny;
	logic               emit_ok;
	logic               div_go;
	logic [NUM_W-1:0]   acc_x_n, acc_y_n;
	logic [HW+SLOT_W-1:0] head_ext;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_take   = in_valid && in_ready;

	assign in_neg_x = touch_x < prev_x_q;
	assign in_neg_y = touch_y < prev_y_q;
	assign in_adx   = in_neg_x ? (prev_x_q - touch_x) : (touch_x - prev_x_q);
	assign in_ady   = in_neg_y ? (prev_y_q - touch_y) : (touch_y - prev_y_q);
	assign in_span  = (in_adx > in_ady) ? in_adx : in_ady;

	// wrap-safe elapsed time
	assign elapsed = now_ms - prev_time_q;
	assign joins   = have_prev_q && (elapsed < TIME_W'(gap_q));

	assign step_eff = (step_q == '0) ? STEP_W'(1) : step_q;
	assign cap_eff  = (cap_q == '0) ? CAP_W'(1) :
	                  ((cap_q > RESULT_CAP) ? RESULT_CAP : cap_q);

	// clamp the segment count into 1..cap
	always_comb begin
		if (rsp.quo == '0) begin
			steps_n = CAP_W'(1);
		end else if (rsp.quo > COORD_W'(cap_eff)) begin
			steps_n = cap_eff;
		end else begin
			steps_n = rsp.quo[CAP_W-1:0];
		end
	end

	// signed offset from the segment start, truncated toward zero
	assign nx = neg_x_q ? (base_x_q - qx_q) : (base_x_q + qx_q);
	assign ny = neg_y_q ? (base_y_q - rsp.quo) : (base_y_q + rsp.quo);

	assign acc_x_n  = acc_x_q + NUM_W'(adx_q);
	assign acc_y_n  = acc_y_q + NUM_W'(ady_q);
	assign emit_ok  = !out_valid_q || out_ready;
	assign head_ext = {{SLOT_W{1'b0}}, head_q};

	// divider start: segment sizing, then x and y for every point
	assign div_go = (state_q == ST_IDLE && in_take && !kind && joins) ||
	                ((state_q == ST_SPAN || state_q == ST_XDIV) && rsp.done) ||
	                (state_q == ST_EMIT && emit_ok && !pend_last_q);

	tsi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gap_q       <= GAP_RESET;
			step_q      <= STEP_RESET;
			cap_q       <= CAP_RESET;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_time_q <= '0;
			have_prev_q <= 1'b0;
			head_q      <= '0;
			base_x_q    <= '0;
			base_y_q    <= '0;
			neg_x_q     <= 1'b0;
			neg_y_q     <= 1'b0;
			adx_q       <= '0;
			ady_q       <= '0;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			steps_q     <= '0;
			idx_q       <= '0;
			qx_q        <= '0;
			stamp_q     <= '0;
			pend_x_q    <= '0;
			pend_y_q    <= '0;
			pend_last_q <= 1'b0;
			out_valid_q <= 1'b0;
			px_q        <= '0;
			py_q        <= '0;
			stamp_out_q <= '0;
			slot_q      <= '0;
			last_q      <= 1'b0;
			req_q       <= '0;
		end else begin
			req_q.go <= div_go;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_GAP:  gap_q  <= cfg_data;
					REG_STEP: step_q <= cfg_data[STEP_W-1:0];
					REG_CAP:  cap_q  <= cfg_data[CAP_W-1:0];
					default: ;
				endcase
			end

			// a point is loaded when the register is free, held while stalled
			out_valid_q <= (state_q == ST_EMIT && emit_ok) || (out_valid_q && !out_ready);

			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (kind) begin
							// finger lift: stroke ends, position and head kept
							have_prev_q <= 1'b0;
						end else begin
							stamp_q     <= (now_ms == '0) ? TIME_W'(1) : now_ms;
							base_x_q    <= prev_x_q;
							base_y_q    <= prev_y_q;
							neg_x_q     <= in_neg_x;
							neg_y_q     <= in_neg_y;
							adx_q       <= in_adx;
							ady_q       <= in_ady;
							prev_x_q    <= touch_x;
							prev_y_q    <= touch_y;
							prev_time_q <= now_ms;
							have_prev_q <= 1'b1;
							if (joins) begin
								// size the segment first
								req_q.num <= NUM_W'(in_span);
								req_q.den <= step_eff;
								state_q   <= ST_SPAN;
							end else begin
								pend_x_q    <= touch_x;
								pend_y_q    <= touch_y;
								pend_last_q <= 1'b1;
								state_q     <= ST_EMIT;
							end
						end
					end
				end
				ST_SPAN: begin
					if (rsp.done) begin
						steps_q   <= steps_n;
						idx_q     <= CAP_W'(1);
						acc_x_q   <= NUM_W'(adx_q);
						acc_y_q   <= NUM_W'(ady_q);
						req_q.num <= NUM_W'(adx_q);
						req_q.den <= DEN_W'(steps_n);
						state_q   <= ST_XDIV;
					end
				end
				ST_XDIV: begin
					if (rsp.done) begin
						qx_q      <= rsp.quo;
						req_q.num <= acc_y_q;
						state_q   <= ST_YDIV;
					end
				end
				ST_YDIV: begin
					if (rsp.done) begin
						pend_x_q    <= nx;
						pend_y_q    <= ny;
						pend_last_q <= (idx_q == steps_q);
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_ok) begin
						px_q        <= pend_x_q;
						py_q        <= pend_y_q;
						stamp_out_q <= stamp_q;
						slot_q      <= head_ext[SLOT_W-1:0];
						last_q      <= pend_last_q;
						head_q      <= (head_q == HW'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
						if (pend_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							// next point: accumulate |d|*i instead of multiplying
							idx_q     <= idx_q + 1'b1;
							acc_x_q   <= acc_x_n;
							acc_y_q   <= acc_y_n;
							req_q.num <= acc_x_n;
							state_q   <= ST_XDIV;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign point_x    = px_q;
	assign point_y    = py_q;
	assign stamp      = stamp_out_q;
	assign slot       = slot_q;
	assign last_point = last_q;

endmodule

FILE: src/tsi_checker.sv
// ----------------------------------------------------------------------------
// tsi_checker
// port-level checks on the touch stroke interpolator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "touch_stroke_interpolator_top_defines.svh"

module tsi_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          kind,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [tsi_pkg::COORD_W-1:0]   point_x,
	input logic [tsi_pkg::TIME_W-1:0]    stamp,
	input logic [tsi_pkg::SLOT_W-1:0]    slot
);
	import tsi_pkg::*;

	// a touch sample makes the block busy in the cycle after it is taken
	`TSI_ASSERT_NEXT(a_sample_busy, in_valid && in_ready && !kind, !in_ready)

	// a finger lift is absorbed at once
	`TSI_ASSERT_NEXT(a_lift_idle, in_valid && in_ready && kind, in_ready)

	// zero time stamps are replaced before they leave
	`TSI_ASSERT_NOW(a_stamp_nonzero, out_valid, stamp != '0)

	// a stalled point transaction holds its payload
	`TSI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(point_x) && $stable(stamp) && $stable(slot))

endmodule

bind touch_stroke_interpolator_top tsi_checker u_tsi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.kind      (kind),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.point_x   (point_x),
	.stamp     (stamp),
	.slot      (slot)
);
